### rtl/dxt_block_decoder_core_assert.svh
// ---------------------------------------------------------------------------
// DXT block decoder assertion macros
// Concurrent checks on clk with rst as the disable; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_CORE_ASSERT_SVH
`define DXT_BLOCK_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DXT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DXT_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) trig |=> cond) else $error(msg);
`else
`define DXT_ASSERT(name, prop, msg)
`define DXT_ASSERT_NEXT(name, trig, cond, msg)
`endif
`endif

### rtl/dxtbd_pkg.sv
// ---------------------------------------------------------------------------
// DXT block decoder package
// Word types, format codes and the constant-divide helpers of the palette.
// ---------------------------------------------------------------------------
package dxtbd_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [63:0] color_word;
    logic [63:0] alpha_word;
    logic [2:0]  cols_valid;
    logic [2:0]  rows_valid;
  } blk_word_t;

  typedef struct packed {
    logic [1:0] pixel_x;
    logic [1:0] pixel_y;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last;
  } pix_word_t;

  // Fully decoded block, ready for per-pixel selection.
  typedef struct packed {
    logic [1:0]       fmt;
    logic [31:0]      idx;
    logic [63:0]      aw;
    logic [1:0]       cols_m1;
    logic [1:0]       rows_m1;
    rgb_t [3:0]       pal;
    logic [7:0]       pal3_a;
    logic [7:0][7:0]  alev;
  } blk_t;

  function automatic rgb_t expand565(input logic [15:0] v);
    rgb_t c;
    c[CH_R] = {v[15:11], v[15:13]};
    c[CH_G] = {v[10:5], v[10:9]};
    c[CH_B] = {v[4:0], v[4:2]};
    return c;
  endfunction

  // Reciprocal multiplies; exact floor over the full range of each sum.
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] prod;
    prod = 20'(v) * 20'd683;
    return prod[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [24:0] prod;
    prod = 25'(v) * 25'd3277;
    return prod[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [24:0] prod;
    prod = 25'(v) * 25'd2341;
    return prod[21:14];
  endfunction

endpackage

### rtl/dxt_block_decoder_core.sv
// ---------------------------------------------------------------------------
// DXT block decoder core
// Decodes DXT1/3/5 4x4 blocks into BGRA pixels, one pixel per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   blk carries one compressed block per word (blk_valid/blk_ready). pix
//   carries one decoded pixel per word (pix_valid/pix_ready), row-major,
//   clipped to cols_valid x rows_valid, with last set on the final pixel.
//   cfg_data selects the format (DXT1, DXT3, DXT5; code three acts as DXT5)
//   and is always accepted; write it only while the block is idle.
//   The first pixel of a block reaches pix via stage 1, stage 2, the pixel
//   sequencer and the output register. Throughput: one pixel per cycle
//   while pix is not stalled; a block holds the sequencer for its cols*rows
//   pixels (16 if full); two decode stages ahead of it take the next blocks.
//   A block with zero columns or rows is accepted and yields no pixels.
//   Reset clears all valid bits and selects DXT1.
//   When pix is stalled the output register holds its word and backpressure
//   moves stage by stage back to blk_ready; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "dxt_block_decoder_core_assert.svh"

module dxt_block_decoder_core
  import dxtbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       blk_valid,
  output logic       blk_ready,
  input  blk_word_t  blk,
  output logic       pix_valid,
  input  logic       pix_ready,
  output pix_word_t  pix,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic [1:0] fmt;

  // Stage 1: endpoints expanded, weighted sums formed.
  logic             s1_v;
  logic [1:0]       s1_fmt;
  logic [31:0]      s1_idx;
  logic [63:0]      s1_aw;
  logic [1:0]       s1_cols_m1;
  logic [1:0]       s1_rows_m1;
  rgb_t             s1_p0;
  rgb_t             s1_p1;
  logic             s1_four;
  logic [2:0][9:0]  s1_sa;
  logic [2:0][9:0]  s1_sb;
  logic [2:0][8:0]  s1_sh;
  logic [7:0]       s1_a0;
  logic [7:0]       s1_a1;
  logic             s1_agt;
  logic [5:0][10:0] s1_s7;
  logic [3:0][10:0] s1_s5;

  // Stage 2: palette and alpha levels. Stage 3: pixel sequencer.
  logic       s2_v;
  blk_t       s2;
  blk_t       s2_next;
  logic       s3_v;
  blk_t       s3;
  logic [1:0] s3_x;
  logic [1:0] s3_y;

  logic       s1_take, s2_take, s3_load, out_take, emit, s3_last, nonempty;
  logic [1:0] cols_m1_in, rows_m1_in;
  rgb_t       p0_in, p1_in;
  pix_word_t  pix_next;

  assign cfg_ready = 1'b1;

  // Handshake chain: each stage frees when its content moves on.
  assign out_take  = !pix_valid || pix_ready;
  assign emit      = s3_v && out_take;
  assign s3_last   = (s3_x == s3.cols_m1) && (s3_y == s3.rows_m1);
  assign s3_load   = s2_v && (!s3_v || (emit && s3_last));
  assign s2_take   = !s2_v || s3_load;
  assign s1_take   = !s1_v || s2_take;
  assign blk_ready = s1_take;

  assign nonempty   = (blk.cols_valid != 3'd0) && (blk.rows_valid != 3'd0);
  assign cols_m1_in = (blk.cols_valid >= 3'd4) ? 2'd3 : 2'(blk.cols_valid - 3'd1);
  assign rows_m1_in = (blk.rows_valid >= 3'd4) ? 2'd3 : 2'(blk.rows_valid - 3'd1);
  assign p0_in      = expand565(blk.color_word[15:0]);
  assign p1_in      = expand565(blk.color_word[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt       <= FMT_DXT1;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fmt <= cfg_data;
      end
      if (s1_take) begin
        s1_v <= blk_valid && nonempty;
      end
      if (s2_take) begin
        s2_v <= s1_v;
      end
      if (s3_load) begin
        s3_v <= 1'b1;
      end else if (emit && s3_last) begin
        s3_v <= 1'b0;
      end
      if (out_take) begin
        pix_valid <= s3_v;
      end
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_fmt     <= fmt;
      s1_idx     <= blk.color_word[63:32];
      s1_aw      <= blk.alpha_word;
      s1_cols_m1 <= cols_m1_in;
      s1_rows_m1 <= rows_m1_in;
      s1_p0      <= p0_in;
      s1_p1      <= p1_in;
      s1_four    <= (fmt != FMT_DXT1) || (blk.color_word[15:0] > blk.color_word[31:16]);
      for (int c = 0; c < 3; c++) begin
        s1_sa[c] <= {1'b0, p0_in[c], 1'b0} + 10'(p1_in[c]);
        s1_sb[c] <= 10'(p0_in[c]) + {1'b0, p1_in[c], 1'b0};
        s1_sh[c] <= 9'(p0_in[c]) + 9'(p1_in[c]);
      end
      s1_a0  <= blk.alpha_word[7:0];
      s1_a1  <= blk.alpha_word[15:8];
      s1_agt <= blk.alpha_word[7:0] > blk.alpha_word[15:8];
      for (int i = 1; i < 7; i++) begin
        s1_s7[i-1] <= 11'(blk.alpha_word[7:0]) * 11'(7 - i)
                    + 11'(blk.alpha_word[15:8]) * 11'(i);
      end
      for (int i = 1; i < 5; i++) begin
        s1_s5[i-1] <= 11'(blk.alpha_word[7:0]) * 11'(5 - i)
                    + 11'(blk.alpha_word[15:8]) * 11'(i);
      end
    end
  end

  // Stage 2: the thirds, halves and alpha interpolation.
  always_comb begin
    s2_next.fmt     = s1_fmt;
    s2_next.idx     = s1_idx;
    s2_next.aw      = s1_aw;
    s2_next.cols_m1 = s1_cols_m1;
    s2_next.rows_m1 = s1_rows_m1;
    s2_next.pal[0]  = s1_p0;
    s2_next.pal[1]  = s1_p1;
    for (int c = 0; c < 3; c++) begin
      if (s1_four) begin
        s2_next.pal[2][c] = div3(s1_sa[c]);
        s2_next.pal[3][c] = div3(s1_sb[c]);
      end else begin
        s2_next.pal[2][c] = s1_sh[c][8:1];
        s2_next.pal[3][c] = 8'd0;
      end
    end
    s2_next.pal3_a  = s1_four ? 8'd255 : 8'd0;
    s2_next.alev[0] = s1_a0;
    s2_next.alev[1] = s1_a1;
    if (s1_agt) begin
      for (int i = 1; i < 7; i++) begin
        s2_next.alev[i+1] = div7(s1_s7[i-1]);
      end
    end else begin
      for (int i = 1; i < 5; i++) begin
        s2_next.alev[i+1] = div5(s1_s5[i-1]);
      end
      s2_next.alev[6] = 8'd0;
      s2_next.alev[7] = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2 <= s2_next;
    end
  end

  // Stage 3: walk the valid pixels of the held block.
  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3   <= s2;
      s3_x <= 2'd0;
      s3_y <= 2'd0;
    end else if (emit) begin
      if (s3_x == s3.cols_m1) begin
        s3_x <= 2'd0;
        s3_y <= s3_y + 2'd1;
      end else begin
        s3_x <= s3_x + 2'd1;
      end
    end
  end

  logic [3:0] pos;
  logic [1:0] ci;
  logic [3:0] a4;
  logic [5:0] apos;
  logic [2:0] ai;
  rgb_t       col;

  assign pos  = {s3_y, s3_x};
  assign ci   = s3.idx[{pos, 1'b0} +: 2];
  assign a4   = s3.aw[{pos, 2'b00} +: 4];
  assign apos = 6'd16 + {1'b0, pos, 1'b0} + {2'b00, pos};
  assign ai   = s3.aw[apos +: 3];
  assign col  = s3.pal[ci];

  always_comb begin
    pix_next.pixel_x = s3_x;
    pix_next.pixel_y = s3_y;
    pix_next.blue    = col[CH_B];
    pix_next.green   = col[CH_G];
    pix_next.red     = col[CH_R];
    pix_next.last    = s3_last;
    case (s3.fmt)
      FMT_DXT1: pix_next.alpha = (ci == 2'd3) ? s3.pal3_a : 8'd255;
      FMT_DXT3: pix_next.alpha = {a4, a4};
      default:  pix_next.alpha = s3.alev[ai];
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix <= pix_next;
    end
  end

  `DXT_ASSERT(a_cnt_range, s3_v |-> (s3_x <= s3.cols_m1) && (s3_y <= s3.rows_m1), "pixel counter outside block")
  `DXT_ASSERT_NEXT(a_load_origin, s3_load, s3_v && (s3_x == 2'd0) && (s3_y == 2'd0), "block load did not start at origin")
  `DXT_ASSERT_NEXT(a_drain, emit && s3_last && !s3_load, !s3_v, "sequencer kept a finished block")
  `DXT_ASSERT_NEXT(a_last_out, emit && s3_last, pix_valid && pix.last, "final pixel word lost its last flag")

endmodule

### tb/dxt_pixel_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// DXT block decoder pixel scoreboard
// Predicts the BGRA pixel words of each accepted block for the current format
// and checks the decoder's pixel words against them in order.
// ---------------------------------------------------------------------------
package dxt_pixel_scoreboard_pkg;
  import dxtbd_pkg::*;

  class pixel_scoreboard;
    logic [1:0]  fmt;
    pix_word_t   expected_q[$];
    int unsigned errors;

    function new();
      fmt = FMT_DXT1;
      errors = 0;
    endfunction

    function void set_format(input logic [1:0] f);
      fmt = f;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Bit replication of a 565 endpoint, packed as {r, g, b}.
    function logic [23:0] widen565(input logic [15:0] v);
      return {v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2]};
    endfunction

    function void note_block(input blk_word_t b);
      int          pal[4][3];
      int          pal_alpha[4];
      int          lev[8];
      logic [23:0] rgb;
      int unsigned ncols, nrows, total, emitted, p, ci, a;
      logic [3:0]  nib;
      pix_word_t   w;
      bit          four_color;

      ncols = (b.cols_valid > 3'd4) ? 4 : 32'(b.cols_valid);
      nrows = (b.rows_valid > 3'd4) ? 4 : 32'(b.rows_valid);
      total = ncols * nrows;
      emitted = 0;

      rgb = widen565(b.color_word[15:0]);
      pal[0][0] = int'(rgb[23:16]); pal[0][1] = int'(rgb[15:8]); pal[0][2] = int'(rgb[7:0]);
      rgb = widen565(b.color_word[31:16]);
      pal[1][0] = int'(rgb[23:16]); pal[1][1] = int'(rgb[15:8]); pal[1][2] = int'(rgb[7:0]);
      pal_alpha[0] = 255;
      pal_alpha[1] = 255;
      pal_alpha[2] = 255;

      // Only DXT1 drops to three colors plus transparent black.
      four_color = (fmt != FMT_DXT1) || (b.color_word[15:0] > b.color_word[31:16]);
      for (int ch = 0; ch < 3; ch++) begin
        if (four_color) begin
          pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
          pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
        end else begin
          pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
          pal[3][ch] = 0;
        end
      end
      pal_alpha[3] = four_color ? 255 : 0;

      lev[0] = int'(b.alpha_word[7:0]);
      lev[1] = int'(b.alpha_word[15:8]);
      if (lev[0] > lev[1]) begin
        for (int i = 1; i < 7; i++)
          lev[i + 1] = ((7 - i) * lev[0] + i * lev[1]) / 7;
      end else begin
        for (int i = 1; i < 5; i++)
          lev[i + 1] = ((5 - i) * lev[0] + i * lev[1]) / 5;
        lev[6] = 0;
        lev[7] = 255;
      end

      for (int y = 0; y < nrows; y++) begin
        for (int x = 0; x < ncols; x++) begin
          p = 4 * y + x;
          ci = 32'(b.color_word[32 + 2 * p +: 2]);
          if (fmt == FMT_DXT1) begin
            a = pal_alpha[ci];
          end else if (fmt == FMT_DXT3) begin
            nib = b.alpha_word[4 * p +: 4];
            a = 32'({nib, nib});
          end else begin
            a = lev[b.alpha_word[16 + 3 * p +: 3]];
          end
          w.pixel_x = x[1:0];
          w.pixel_y = y[1:0];
          w.blue    = pal[ci][2][7:0];
          w.green   = pal[ci][1][7:0];
          w.red     = pal[ci][0][7:0];
          w.alpha   = a[7:0];
          w.last    = (emitted + 1 == total);
          expected_q.insert(expected_q.size(), w);
          emitted++;
        end
      end
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(input pix_word_t got);
      pix_word_t want;
      if (expected_q.size() == 0) begin
        $error("pixel word with no block outstanding: x=%0d y=%0d",
               got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
      check_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
      check_field("blue", 32'(want.blue), 32'(got.blue));
      check_field("green", 32'(want.green), 32'(got.green));
      check_field("red", 32'(want.red), 32'(got.red));
      check_field("alpha", 32'(want.alpha), 32'(got.alpha));
      check_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

endpackage

### tb/testbench.sv
// ---------------------------------------------------------------------------
// DXT block decoder core testbench
// Sends directed and random compressed blocks in every format, with random
// gaps on the block side and random stalls on the pixel side, and checks
// every pixel word against a scoreboard prediction.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dxtbd_pkg::*;
  import dxt_pixel_scoreboard_pkg::*;

  localparam logic [1:0] FMT_CODE3 = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_PER_PHASE = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       blk_valid = 1'b0;
  logic       blk_ready;
  blk_word_t  blk = '0;
  logic       pix_valid;
  logic       pix_ready = 1'b0;
  pix_word_t  pix;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = FMT_DXT1;

  pixel_scoreboard board = new();
  bit blk_gaps_on = 1'b1;
  bit pix_stalls_on = 1'b1;

  dxt_block_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic blk_word_t make_block(input logic [63:0] cw, input logic [63:0] aw,
                                           input logic [2:0] cols, input logic [2:0] rows);
    blk_word_t b;
    b.color_word = cw;
    b.alpha_word = aw;
    b.cols_valid = cols;
    b.rows_valid = rows;
    return b;
  endfunction

  // DXT5 alpha word whose pixel indices walk through all eight levels.
  function automatic logic [63:0] level_sweep(input logic [7:0] a0, input logic [7:0] a1);
    logic [63:0] aw;
    aw = {48'h0, a1, a0};
    for (int p = 0; p < 16; p++)
      aw[16 + 3 * p +: 3] = p[2:0];
    return aw;
  endfunction

  function automatic blk_word_t rand_block();
    logic [63:0] cw, aw;
    logic [2:0]  cols, rows;
    int unsigned r;
    cw = {$urandom, $urandom};
    aw = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) cw[31:16] = cw[15:0];
    if ($urandom_range(0, 9) == 0) aw[15:8] = aw[7:0];
    r = $urandom_range(0, 9);
    if (r < 5) begin
      cols = 3'd4;
      rows = 3'd4;
    end else if (r < 8) begin
      cols = 3'($urandom_range(1, 4));
      rows = 3'($urandom_range(1, 4));
    end else begin
      cols = 3'($urandom_range(0, 7));
      rows = 3'($urandom_range(0, 7));
    end
    return make_block(cw, aw, cols, rows);
  endfunction

  // Valid is lowered only when a gap follows, so a back-to-back word keeps it
  // high with a single assignment in the accepting step.
  task automatic send_block(input blk_word_t b);
    int unsigned gap;
    gap = (blk_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      blk_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blk <= b;
    blk_valid <= 1'b1;
    do @(posedge clk); while (!blk_ready);
    board.note_block(b);
  endtask

  // Blocks with no pixels never enter the decoder, so an empty queue leaves it
  // idle; the DRAIN_CYCLES wait still comes before the format changes.
  task automatic write_format(input logic [1:0] f);
    blk_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data <= f;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_format(f);
  endtask

  task automatic send_random(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        blk_gaps_on = ($urandom_range(0, 3) != 0);
        pix_stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_block(rand_block());
    end
  endtask

  // Pixel side: check each accepted word, then pick the next ready.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pix_valid && pix_ready) board.check_pixel(pix);
      if (stall_left > 0) begin
        pix_ready <= 1'b0;
        stall_left--;
      end else begin
        pix_ready <= 1'b1;
        if (pix_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("dxt_block_decoder_core: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // DXT1 out of reset: four-color, three-color and equal endpoints.
    send_block(make_block({32'hE4E4_E4E4, 16'h001F, 16'hF800}, {$urandom, $urandom},
                          3'd4, 3'd4));
    send_block(make_block({32'h1B1B_1B1B, 16'hFFFF, 16'h0000}, {$urandom, $urandom},
                          3'd4, 3'd4));
    send_block(make_block({32'hE4E4_E4E4, 16'h7BEF, 16'h7BEF}, 64'h0, 3'd4, 3'd4));
    send_block(make_block(64'h0, '1, 3'd4, 3'd4));
    send_block(make_block('1, '1, 3'd4, 3'd4));
    // Empty blocks and oversized dimensions.
    send_block(make_block({$urandom, $urandom}, 64'h0, 3'd0, 3'd4));
    send_block(make_block({$urandom, $urandom}, 64'h0, 3'd4, 3'd0));
    send_block(make_block({32'hE4E4_E4E4, 16'h07E0, 16'hF81F}, 64'h0, 3'd7, 3'd5));
    send_block(make_block({$urandom, $urandom}, 64'h0, 3'd1, 3'd1));
    send_block(make_block({$urandom, $urandom}, 64'h0, 3'd3, 3'd2));
    send_random(RANDOM_PER_PHASE);

    // DXT3: explicit alpha, four colors even when c0 <= c1.
    write_format(FMT_DXT3);
    send_block(make_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, 64'hFEDC_BA98_7654_3210,
                          3'd4, 3'd4));
    send_block(make_block({32'h1B1B_1B1B, 16'h8410, 16'h8410}, 64'h0, 3'd4, 3'd4));
    send_block(make_block({$urandom, $urandom}, '1, 3'd4, 3'd4));
    send_block(make_block({$urandom, $urandom}, {$urandom, $urandom}, 3'd2, 3'd3));
    send_random(RANDOM_PER_PHASE);

    // DXT5: both level modes and the endpoint extremes.
    write_format(FMT_DXT5);
    send_block(make_block({$urandom, $urandom}, level_sweep(8'hF0, 8'h10), 3'd4, 3'd4));
    send_block(make_block({$urandom, $urandom}, level_sweep(8'h10, 8'hF0), 3'd4, 3'd4));
    send_block(make_block({$urandom, $urandom}, level_sweep(8'h80, 8'h80), 3'd4, 3'd4));
    send_block(make_block({$urandom, $urandom}, level_sweep(8'h00, 8'hFF), 3'd4, 3'd4));
    send_block(make_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, level_sweep(8'hFF, 8'h00),
                          3'd4, 3'd4));
    send_random(RANDOM_PER_PHASE);

    // Format code three decodes as DXT5.
    write_format(FMT_CODE3);
    send_block(make_block({$urandom, $urandom}, level_sweep(8'h20, 8'hC0), 3'd4, 3'd4));
    send_block(make_block({$urandom, $urandom}, level_sweep(8'hC0, 8'h20), 3'd4, 3'd4));
    send_random(RANDOM_PER_PHASE);

    write_format(FMT_DXT1);
    send_random(RANDOM_PER_PHASE);

    blk_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("dxt_block_decoder_core: match");
    end else begin
      $display("dxt_block_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dxtbd_pkg.sv
rtl/dxt_block_decoder_core.sv
tb/dxt_pixel_scoreboard_pkg.sv
tb/testbench.sv
